/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sdf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg
// types and constants shared by the distinct filter modules
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;

    // entries held in one memory row, compared side by side
    localparam int LANES   = 8;
    localparam int LANE_SH = 3;

    localparam logic [COUNT_W-1:0] KEPT_MAX = 16'hFFFF;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [LANES-1:0][VALUE_W-1:0] row_t;

endpackage
`default_nettype wire

/* rtl/sdf_seen_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_seen_mem
// seen-set storage: rows of lanes, one lane written, one row read per cycle
// ----------------------------------------------------------------------------
module sdf_seen_mem #(
    parameter int ROW_W = 3
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [ROW_W-1:0]            wr_row,
    input  wire logic [sdf_pkg::LANE_SH-1:0] wr_lane,
    input  wire sdf_pkg::value_t             wr_data,
    input  wire logic                        rd_en,
    input  wire logic [ROW_W-1:0]            rd_row,
    output sdf_pkg::row_t                    rd_data
);
    import sdf_pkg::*;

    localparam int ROW_DEPTH = 1 << ROW_W;

    row_t seen_mem [ROW_DEPTH];
    row_t rd_data_reg;

    // lane-enabled write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seen_mem[wr_row][wr_lane] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= seen_mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/sdf_lane_match.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_lane_match
// compares a key against every lane of one row, skipping lanes at or past the fill
// ----------------------------------------------------------------------------
module sdf_lane_match #(
    parameter int ROW_W  = 3,
    parameter int FILL_W = 7
) (
    input  wire sdf_pkg::row_t    row_data,
    input  wire logic [ROW_W-1:0] row,
    input  wire logic [FILL_W-1:0] fill,
    input  wire sdf_pkg::value_t  key,
    output logic                  hit
);
    import sdf_pkg::*;

    localparam int EXT_W = ROW_W + LANE_SH + 1;

    logic [LANES-1:0] lane_hit;
    logic [EXT_W-1:0] fill_ext;

    assign fill_ext = EXT_W'(fill);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [EXT_W-1:0] entry_idx;
        assign entry_idx   = EXT_W'({row, LANE_SH'(l)});
        assign lane_hit[l] = (entry_idx < fill_ext) && (row_data[l] == key);
    end

    assign hit = |lane_hit;

endmodule
`default_nettype wire

/* rtl/stream_distinct_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stream_distinct_filter
// passes the first occurrence of each value of an array, drops repeats,
// and reports the kept count with the last element
// ----------------------------------------------------------------------------
// search: rows 0 .. ceil(fill / 8)-1 are read one after another, then the
//   search decides, fill being the number of stored values of the current array
// one search runs at a time, a new one starting as the last decides; the single
//   read port of the seen-set memory scans one 8-entry row per cycle
// reset: control, fill, count and overflow clear at once; the memory is not
//   cleared, entries at or past the fill are never matched
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stream_distinct_filter #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic signed [sdf_pkg::VALUE_W-1:0] value,
    input  wire logic                          last,
    // result channel
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic signed [sdf_pkg::VALUE_W-1:0] value_res,
    output logic                               is_kept,
    output logic [sdf_pkg::COUNT_W-1:0]        kept_count,
    output logic                               end_of_array,
    output logic                               overflow
);
    import sdf_pkg::*;

    // memory geometry derived from the capacity
    localparam int ROWS   = (CAPACITY + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(ROWS + 1);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int EXT_W  = ROW_W + LANE_SH + 1;

    // one-entry holding stage in front of the search
    logic         hold_valid_reg, hold_valid_next;
    value_t       hold_value_reg;
    logic         hold_last_reg;

    // transaction under search
    logic         busy_reg, busy_next;
    value_t       cur_value_reg;
    logic         cur_last_reg;

    // row scan sequencer
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             rd_pending_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic             match_acc_reg, match_acc_next;

    // per-array state
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [COUNT_W-1:0] kept_total_reg, kept_total_next;
    logic               ovf_reg, ovf_next;

    // result register
    logic               res_valid_reg, res_valid_next;
    value_t             res_value_reg;
    logic               res_kept_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_eoa_reg;
    logic               res_ovf_reg;

    logic               item_fire;
    logic               load_cur;
    value_t             next_value;
    logic               next_last;
    logic [EXT_W-1:0]   fill_ext;
    logic [CNT_W-1:0]   rows_needed;
    logic               more_rows;
    logic               issue;
    logic               scan_done;
    logic               hit_now;
    logic               found;
    logic               kept;
    logic               emit;
    logic               res_free;
    logic               decide;
    logic               has_room;
    logic               wr_en;
    logic [ROW_W-1:0]   wr_row;
    logic [LANE_SH-1:0] wr_lane;
    logic [COUNT_W-1:0] kept_new;
    logic               ovf_new;
    row_t               rd_data;

    // ------------------------------------------------------------------
    // input side: the holding stage frees the port from the search
    // ------------------------------------------------------------------
    assign item_ready = !hold_valid_reg;
    assign item_fire  = item_valid && item_ready;

    // a new search starts when the searcher is free or finishing now
    assign load_cur   = (!busy_reg || decide) && (hold_valid_reg || item_fire);
    assign next_value = hold_valid_reg ? hold_value_reg : value_t'(value);
    assign next_last  = hold_valid_reg ? hold_last_reg : last;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (item_fire && !load_cur)
        begin
            hold_valid_next = 1'b1;
        end
        else if (load_cur && hold_valid_reg)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // row scan: rows 0 .. ceil(fill/8)-1, one read per cycle
    // ------------------------------------------------------------------
    assign fill_ext    = EXT_W'(fill_reg);
    assign rows_needed = CNT_W'((fill_ext + EXT_W'(LANES - 1)) >> LANE_SH);
    assign more_rows   = issue_cnt_reg < rows_needed;
    assign issue       = busy_reg && more_rows;
    assign scan_done   = busy_reg && !more_rows;

    // the last row's compare folds straight into the decision
    assign found    = match_acc_reg || (rd_pending_reg && hit_now);
    assign kept     = !found;
    assign emit     = kept || cur_last_reg;
    assign res_free = !res_valid_reg || res_ready;
    assign decide   = scan_done && (!emit || res_free);

    // insertion at the fill position, written in the decision cycle so the
    // next search, which issues its first read no earlier than the cycle after, sees it
    assign has_room = fill_reg < FILL_W'(CAPACITY);
    assign wr_en    = decide && kept && has_room;
    assign wr_row   = ROW_W'(fill_ext >> LANE_SH);
    assign wr_lane  = fill_ext[LANE_SH-1:0];

    // saturating kept count and sticky overflow
    always_comb
    begin
        kept_new = kept_total_reg;
        if (kept && (kept_total_reg != KEPT_MAX))
        begin
            kept_new = kept_total_reg + COUNT_W'(1);
        end
    end

    assign ovf_new = ovf_reg || (kept && !has_room);

    always_comb
    begin
        busy_next       = busy_reg;
        issue_cnt_next  = issue_cnt_reg;
        match_acc_next  = match_acc_reg || (rd_pending_reg && hit_now);
        fill_next       = fill_reg;
        kept_total_next = kept_total_reg;
        ovf_next        = ovf_reg;

        if (issue)
        begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end

        if (decide)
        begin
            busy_next = 1'b0;
            if (cur_last_reg)
            begin
                // array done: the set empties for the next one
                fill_next       = '0;
                kept_total_next = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                kept_total_next = kept_new;
                ovf_next        = ovf_new;
                if (wr_en)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
        end

        if (load_cur)
        begin
            busy_next      = 1'b1;
            issue_cnt_next = '0;
            match_acc_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (decide && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // seen-set memory and lane compare
    // ------------------------------------------------------------------
    sdf_seen_mem #(
        .ROW_W   (ROW_W)
    ) u_seen_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_lane (wr_lane),
        .wr_data (cur_value_reg),
        .rd_en   (issue),
        .rd_row  (issue_cnt_reg[ROW_W-1:0]),
        .rd_data (rd_data)
    );

    sdf_lane_match #(
        .ROW_W    (ROW_W),
        .FILL_W   (FILL_W)
    ) u_lane_match (
        .row_data (rd_data),
        .row      (rd_row_reg),
        .fill     (fill_reg),
        .key      (cur_value_reg),
        .hit      (hit_now)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            issue_cnt_reg  <= '0;
            rd_pending_reg <= 1'b0;
            match_acc_reg  <= 1'b0;
            fill_reg       <= '0;
            kept_total_reg <= '0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            busy_reg       <= busy_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_pending_reg <= issue;
            match_acc_reg  <= match_acc_next;
            fill_reg       <= fill_next;
            kept_total_reg <= kept_total_next;
            ovf_reg        <= ovf_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_fire && !load_cur)
        begin
            hold_value_reg <= value_t'(value);
            hold_last_reg  <= last;
        end
        if (load_cur)
        begin
            cur_value_reg <= next_value;
            cur_last_reg  <= next_last;
        end
        if (issue)
        begin
            rd_row_reg <= issue_cnt_reg[ROW_W-1:0];
        end
        if (decide && emit)
        begin
            res_value_reg <= kept ? cur_value_reg : '0;
            res_kept_reg  <= kept;
            res_count_reg <= kept_new;
            res_eoa_reg   <= cur_last_reg;
            res_ovf_reg   <= ovf_new;
        end
    end

    assign res_valid    = res_valid_reg;
    assign value_res    = $signed(res_value_reg);
    assign is_kept      = res_kept_reg;
    assign kept_count   = res_count_reg;
    assign end_of_array = res_eoa_reg;
    assign overflow     = res_ovf_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // overflow can only be raised once every entry is in use
    `ASSERT_IMPLIES(a_ovf_needs_full, ovf_reg, fill_reg == FILL_W'(CAPACITY), "overflow below full")
    // the last element empties the set
    `ASSERT_NEXT(a_last_clears, decide && cur_last_reg, (fill_reg == '0) && (kept_total_reg == '0) && !ovf_reg, "set not cleared after last")
    // a row read only belongs to a live search
    `ASSERT_IMPLIES(a_read_in_search, rd_pending_reg, busy_reg, "row read outside a search")
    // a dropped repeat only shows up as the end-of-array transaction
    `ASSERT_IMPLIES(a_drop_is_end, res_valid && !is_kept, end_of_array, "repeat emitted mid-array")

endmodule
`default_nettype wire
